>>> hdl/lpf_pkg.sv
// lpf_pkg: shared type for the largest prime factor block
// holds the sequencer state enum; no dependencies
package lpf_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_CHECK,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage

>>> hdl/lpf_if.sv
// lpf_in_if / lpf_out_if: valid-ready channels of the largest prime factor block
// parameterised on the number width; no package dependencies
interface lpf_in_if #(
  parameter int WIDTH = 31
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface lpf_out_if #(
  parameter int WIDTH = 31
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] largest_factor;

  modport source (output valid, output largest_factor, input ready);
  modport sink (input valid, input largest_factor, output ready);
endinterface

>>> hdl/largest_prime_factor_top.sv
// largest_prime_factor_top: largest prime factor by trial division
// uses lpf_pkg (state enum) and lpf_in_if / lpf_out_if (channels)
//
//   channel    dir   payload                       handshake
//   in_chan    in    value [NUMBER_WIDTH-1:0]      valid/ready, ready only when idle
//   out_chan   out   largest_factor [NUMBER_WIDTH-1:0]  valid/ready, registered
//
// one item at a time through a restoring divider shared by every trial:
// factors of two are stripped first in ST_STRIP, then ST_CHECK tries each
// odd divisor while its square is at most the value, ST_DIV divides bit by
// bit and ST_EVAL divides again by the same divisor after an exact division
// or moves to the next odd divisor; ST_DONE then returns to idle.
// worst case 23169 divisors for 31-bit values.
// rst_n is synchronous and active low; it clears the sequencer and out valid.
// a held result in the output register does not block the next transaction,
// but a finishing item waits in ST_DONE until out_chan.ready takes the old one.
module largest_prime_factor_top #(
  parameter int NUMBER_WIDTH = 31
) (
  input  logic           clk,
  input  logic           rst_n,
  lpf_in_if.sink         in_chan,
  lpf_out_if.source      out_chan
);

  localparam int W     = NUMBER_WIDTH;
  localparam int CNT_W = $clog2(NUMBER_WIDTH);

  lpf_pkg::state_t state_r, state_nxt;

  logic [W-1:0]     n_r, n_nxt;        // value still to factor
  logic [W-1:0]     d_r, d_nxt;        // current odd divisor
  logic [W+1:0]     sq_r, sq_nxt;      // d squared, kept by increments
  logic [W-1:0]     best_r, best_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [W-1:0]     out_factor_r, out_factor_nxt;

  // divider step
  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic         fits;
  logic         sq_le_n;
  logic         out_free;

  assign rem_sh   = {rem_r, quo_r[W-1]};
  assign diff     = rem_sh - {1'b0, d_r};
  assign fits     = !diff[W];
  assign sq_le_n  = (sq_r <= {2'b00, n_r});
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready           = (state_r == lpf_pkg::ST_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.largest_factor = out_factor_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpf_pkg::ST_IDLE: begin
        if (in_chan.valid) state_nxt = lpf_pkg::ST_STRIP;
      end
      lpf_pkg::ST_STRIP: begin
        if (!n_r[0] && n_r > W'(1)) state_nxt = lpf_pkg::ST_STRIP;
        else if (n_r == W'(1))      state_nxt = lpf_pkg::ST_DONE;
        else                        state_nxt = lpf_pkg::ST_CHECK;
      end
      lpf_pkg::ST_CHECK: begin
        if (sq_le_n) state_nxt = lpf_pkg::ST_DIV;
        else         state_nxt = lpf_pkg::ST_DONE;
      end
      lpf_pkg::ST_DIV: begin
        if (cnt_r == '0) state_nxt = lpf_pkg::ST_EVAL;
      end
      lpf_pkg::ST_EVAL: begin
        if (rem_r == '0) state_nxt = lpf_pkg::ST_DIV;
        else             state_nxt = lpf_pkg::ST_CHECK;
      end
      lpf_pkg::ST_DONE: begin
        if (out_free) state_nxt = lpf_pkg::ST_IDLE;
      end
      default: state_nxt = lpf_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_nxt          = n_r;
    d_nxt          = d_r;
    sq_nxt         = sq_r;
    best_nxt       = best_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_factor_nxt = out_factor_r;
    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;
    case (state_r)
      lpf_pkg::ST_IDLE: begin
        n_nxt    = in_chan.value;
        d_nxt    = W'(3);
        sq_nxt   = (W+2)'(9);
        best_nxt = '0;
      end
      lpf_pkg::ST_STRIP: begin
        if (!n_r[0] && n_r > W'(1)) n_nxt = n_r >> 1;
        else if (n_r == W'(1))      res_nxt = W'(2);
      end
      lpf_pkg::ST_CHECK: begin
        quo_nxt = n_r;
        rem_nxt = '0;
        cnt_nxt = CNT_W'(W - 1);
        // no divisor left to try: leftover above one is the answer
        if (!sq_le_n) res_nxt = (n_r > W'(1)) ? n_r : best_r;
      end
      lpf_pkg::ST_DIV: begin
        rem_nxt = fits ? diff[W-1:0] : rem_sh[W-1:0];
        quo_nxt = {quo_r[W-2:0], fits};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      lpf_pkg::ST_EVAL: begin
        if (rem_r == '0) begin
          // divide out again with the same divisor
          best_nxt = d_r;
          n_nxt    = quo_r;
          rem_nxt  = '0;
          cnt_nxt  = CNT_W'(W - 1);
        end else begin
          // (d+2)^2 = d^2 + 4d + 4
          d_nxt  = d_r + W'(2);
          sq_nxt = sq_r + {d_r, 2'b00} + (W+2)'(4);
        end
      end
      lpf_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    d_r          <= d_nxt;
    sq_r         <= sq_nxt;
    best_r       <= best_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    res_r        <= res_nxt;
    out_factor_r <= out_factor_nxt;
  end

  // a trial divisor is always odd and at least three
  a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lpf_pkg::ST_DIV |-> d_r[0] && d_r >= W'(3))
    else $error("trial divisor not odd or below three");

  // a failed trial moves on to the next odd divisor
  a_next_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lpf_pkg::ST_EVAL && rem_r != '0 |=> d_r == $past(d_r) + W'(2))
    else $error("divisor did not advance by two");

  // an exact division always shrinks the value
  a_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lpf_pkg::ST_EVAL && rem_r == '0 |-> quo_r < n_r)
    else $error("exact division did not reduce the value");

  // the answer is zero, two or a prime of at least three, never one
  a_not_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_factor_r != W'(1))
    else $error("result of one delivered");

endmodule

>>> verif/largest_prime_factor_top_tb.sv
// testbench for largest_prime_factor_top: directed edge values, then random values
// depends on lpf_in_if / lpf_out_if and the block; a scoreboard predicts each factor
module largest_prime_factor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 31;
  localparam longint unsigned VALUE_LIMIT = 64'd1 << W;

  class factor_scoreboard;
    logic [W-1:0] factor_q[$];
    int errors = 0;

    // trial division, same order of work as the hardware
    function automatic logic [W-1:0] top_prime_factor(logic [W-1:0] v);
      longint unsigned n, d, found;
      n = 64'(v);
      found = 0;
      while (n % 2 == 0 && n > 1) n = n / 2;
      if (n == 1) return W'(2);
      for (d = 3; d <= n / d; d += 2) begin
        if (n % d == 0) begin
          found = d;
          while (n % d == 0) n = n / d;
        end
      end
      if (n > 1) found = n;
      return found[W-1:0];
    endfunction

    function void note_value(logic [W-1:0] v);
      factor_q.push_back(top_prime_factor(v));
    endfunction

    function void check_factor(logic [W-1:0] got);
      logic [W-1:0] want;
      if (factor_q.size() == 0) begin
        $display("%0t: unexpected result transaction, largest_factor %0d", $time, got);
        errors++;
        return;
      end
      want = factor_q.pop_front();
      if (got !== want) begin
        $display("%0t: largest_factor mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return factor_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   in_quiet = 1'b0;
  factor_scoreboard sb = new();

  lpf_in_if  #(.WIDTH(W)) in_chan();
  lpf_out_if #(.WIDTH(W)) out_chan();

  largest_prime_factor_top #(.NUMBER_WIDTH(W)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  function automatic int idle_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // kept cheap for trial division: the odd part stays small or has only small factors
  function automatic logic [W-1:0] random_value();
    longint unsigned n, f;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return W'($urandom_range(0, 63));
    if (sel < 45) begin
      n = longint'($urandom_range(1, 4095)) << $urandom_range(0, W - 1);
      return n[W-1:0];
    end
    if (sel < 75) begin
      n = 1;
      repeat ($urandom_range(1, 6)) begin
        f = $urandom_range(2, 200);
        repeat ($urandom_range(1, 3)) if (n * f < VALUE_LIMIT) n = n * f;
      end
      return n[W-1:0];
    end
    if (sel < 90) return W'($urandom_range(64, 65536));
    n = longint'($urandom_range(3, 65535) | 1) << $urandom_range(0, 15);
    return n[W-1:0];
  endfunction

  task automatic send_value(input logic [W-1:0] v);
    int gap;
    gap = idle_len(in_quiet);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.value <= v;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_value(v);
  endtask

  // result side: random back-pressure with quiet stretches
  initial begin
    int hold;
    bit quiet;
    out_chan.ready <= 1'b0;
    quiet = 1'b0;
    forever begin
      if ($urandom_range(0, 19) == 0) quiet = ($urandom_range(0, 2) == 0);
      hold = idle_len(quiet);
      if (hold > 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) sb.check_factor(out_chan.largest_factor);
  end

  initial begin
    logic [W-1:0] directed_values[$];
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero, one, powers of two, exact squares, prime powers, large prime remainders
    directed_values = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd6, 31'd9, 31'd15, 31'd25,
                        31'd49, 31'd143, 31'h4000_0000, 31'h7FFF_FFFE, 31'h5555_5555,
                        31'h2AAA_AAAA, 31'd1162261467, 31'd1000003, 31'd1024003072,
                        31'd101711872, 31'h7FFF_FFFF};
    foreach (directed_values[i]) send_value(directed_values[i]);

    for (int i = 0; i < 100; i++) begin
      if (i % 12 == 0) in_quiet = ($urandom_range(0, 3) == 0);
      send_value(random_value());
    end
    in_chan.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // catch any stray transaction after the last expected one
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // the all-ones prime alone tries every odd divisor up to its square root
  initial begin
    #50_000_000;
    $display("%0t: timeout, %0d results still outstanding", $time, sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> largest_prime_factor_top.f
hdl/lpf_pkg.sv
hdl/lpf_if.sv
hdl/largest_prime_factor_top.sv
verif/largest_prime_factor_top_tb.sv
